// ----- hdl/hilbert_allpass_quadrature_pair_defines.svh -----
// ---------------------------------------------------------------------------
// hilbert allpass quadrature pair assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef HILBERT_ALLPASS_QUADRATURE_PAIR_DEFINES_SVH
`define HILBERT_ALLPASS_QUADRATURE_PAIR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge
`define HAQP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequence holds in the cycle after the trigger
`define HAQP_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`else

`define HAQP_ASSERT(lbl, prop)
`define HAQP_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

// ----- hdl/haqp_pkg.sv -----
// ---------------------------------------------------------------------------
// haqp_pkg
// shared constants and controller/datapath interface types
// ---------------------------------------------------------------------------
package haqp_pkg;

  localparam int SECTIONS_DEF  = 4;
  localparam int SAMPLE_DEF    = 24;
  localparam int COEF_FRAC_DEF = 18;

  localparam int COEF_W    = 18;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int COEF_SEL_MAX = 3;

  localparam logic [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
    18'd125672, 18'd229695, 18'd256009, 18'd261488,
    18'd42404,  18'd192159, 18'd247818, 18'd259680
  };

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

// ----- hdl/haqp_dp.sv -----
// ---------------------------------------------------------------------------
// haqp_dp
// shared multiplier datapath: one allpass section at a time, history
// registers, coefficient registers and the output register
// ---------------------------------------------------------------------------
module haqp_dp #(
  parameter int SECTIONS_PER_BRANCH = haqp_pkg::SECTIONS_DEF,
  parameter int SAMPLE_BITS         = haqp_pkg::SAMPLE_DEF,
  parameter int COEF_FRAC_BITS      = haqp_pkg::COEF_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  haqp_pkg::cmd_t                    cmd,
  output haqp_pkg::sts_t                    sts,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  input  logic                              cfg_we,
  input  logic [haqp_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [haqp_pkg::COEF_W-1:0]       cfg_data,
  output logic signed [SAMPLE_BITS-1:0]     in_phase,
  output logic signed [SAMPLE_BITS-1:0]     quadrature
);

  localparam int CW    = haqp_pkg::COEF_W;
  localparam int INNER = SAMPLE_BITS + 2;
  localparam int SUMW  = INNER + 1;
  localparam int PRODW = SUMW + CW + 1;
  localparam int RW    = PRODW + 1;
  localparam int DW    = RW + 1;
  localparam int SECT  = 2 * SECTIONS_PER_BRANCH;
  localparam int SW    = $clog2(SECT);

  localparam logic signed [RW-1:0]    HALF = RW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [DW-1:0]    IMAX = DW'({1'b0, {(INNER-1){1'b1}}});
  localparam logic signed [DW-1:0]    IMIN = ~IMAX;
  localparam logic signed [INNER-1:0] SMAX = INNER'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [INNER-1:0] SMIN = ~SMAX;

  logic [CW-1:0]                coef_r [haqp_pkg::NUM_REGS];
  logic signed [INNER-1:0]      ih1_r [SECT];
  logic signed [INNER-1:0]      ih2_r [SECT];
  logic signed [INNER-1:0]      oh1_r [SECT];
  logic signed [INNER-1:0]      oh2_r [SECT];
  logic [SW-1:0]                sect_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [INNER-1:0]      chain_r;
  logic signed [PRODW-1:0]      prod_r;
  logic signed [SAMPLE_BITS-1:0] a_r;
  logic signed [SAMPLE_BITS-1:0] b_r;
  logic signed [SAMPLE_BITS-1:0] held_r;
  logic signed [SAMPLE_BITS-1:0] out_i_r;
  logic signed [SAMPLE_BITS-1:0] out_q_r;

  logic                         branch_b;
  logic [SW-1:0]                k_loc;
  logic [31:0]                  k_wide;
  logic [1:0]                   k_sel;
  logic [haqp_pkg::REG_IDX_W-1:0] coef_idx;
  logic                         first;
  logic signed [INNER-1:0]      x_cur;
  logic signed [SUMW-1:0]       sum;
  logic signed [CW:0]           coef_s;
  logic signed [PRODW-1:0]      prod_nxt;
  logic signed [RW-1:0]         rnd;
  logic signed [RW-1:0]         shifted;
  logic signed [DW-1:0]         diff;
  logic signed [INNER-1:0]      y;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // section addressing
  assign branch_b = (sect_r >= SW'(SECTIONS_PER_BRANCH));
  assign k_loc    = branch_b ? (sect_r - SW'(SECTIONS_PER_BRANCH)) : sect_r;
  assign k_wide   = 32'(k_loc);
  assign k_sel    = (k_wide > 32'(haqp_pkg::COEF_SEL_MAX)) ?
                    2'(haqp_pkg::COEF_SEL_MAX) : k_wide[1:0];
  assign coef_idx = {branch_b, k_sel};
  assign first    = (sect_r == '0) || (sect_r == SW'(SECTIONS_PER_BRANCH));
  assign x_cur    = first ? INNER'(sample_r) : chain_r;

  // multiply stage
  assign sum      = SUMW'(x_cur) + SUMW'(oh2_r[sect_r]);
  assign coef_s   = $signed({1'b0, coef_r[coef_idx]});
  assign prod_nxt = sum * coef_s;

  // round, subtract and saturate stage
  assign rnd     = RW'(prod_r) + HALF;
  assign shifted = rnd >>> COEF_FRAC_BITS;
  assign diff    = DW'(shifted) - DW'(ih2_r[sect_r]);

  always_comb begin
    if (diff > IMAX) begin
      y = IMAX[INNER-1:0];
    end else if (diff < IMIN) begin
      y = IMIN[INNER-1:0];
    end else begin
      y = diff[INNER-1:0];
    end
    if (y > SMAX) begin
      y_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (y < SMIN) begin
      y_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y[SAMPLE_BITS-1:0];
    end
  end

  assign sts.last = (sect_r == SW'(SECT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < haqp_pkg::NUM_REGS; i++) begin
        coef_r[i] <= haqp_pkg::COEF_RESET[i];
      end
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECT; i++) begin
        ih1_r[i] <= '0;
        ih2_r[i] <= '0;
        oh1_r[i] <= '0;
        oh2_r[i] <= '0;
      end
      held_r <= '0;
      sect_r <= '0;
    end else begin
      if (cmd.load) begin
        sect_r <= '0;
      end
      if (cmd.acc) begin
        ih2_r[sect_r] <= ih1_r[sect_r];
        ih1_r[sect_r] <= x_cur;
        oh2_r[sect_r] <= oh1_r[sect_r];
        oh1_r[sect_r] <= y;
        sect_r        <= sect_r + SW'(1);
      end
      if (cmd.publish) begin
        held_r <= a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample_in;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc) begin
      chain_r <= y;
      if (sect_r == SW'(SECTIONS_PER_BRANCH - 1)) begin
        a_r <= y_sat;
      end
      if (sts.last) begin
        b_r <= y_sat;
      end
    end
    if (cmd.publish) begin
      out_i_r <= held_r;
      out_q_r <= b_r;
    end
  end

  assign in_phase   = out_i_r;
  assign quadrature = out_q_r;

endmodule

// ----- hdl/haqp_ctrl.sv -----
// ---------------------------------------------------------------------------
// haqp_ctrl
// sequencer: accepts a transaction, steps the datapath through every
// section, then hands the result to the output register
// ---------------------------------------------------------------------------
`include "hilbert_allpass_quadrature_pair_defines.svh"

module haqp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output haqp_pkg::cmd_t cmd,
  input  haqp_pkg::sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       pub_ok;
  logic       accept;

  assign pub_ok   = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_DONE) && pub_ok));
  assign accept   = in_valid && !in_stall;

  assign cmd.load    = accept;
  assign cmd.mul     = (state_r == ST_MUL);
  assign cmd.acc     = (state_r == ST_ACC);
  assign cmd.publish = (state_r == ST_DONE) && pub_ok;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = sts.last ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (pub_ok) state_nxt = accept ? ST_MUL : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.publish || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `HAQP_ASSERT(a_busy_stalls, (state_r == ST_MUL || state_r == ST_ACC) |-> in_stall)
  `HAQP_ASSERT(a_publish_free, cmd.publish |-> (!out_valid_r || !out_stall))
  `HAQP_ASSERT_NEXT(a_accept_starts, accept, state_r == ST_MUL)
  `HAQP_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid_r)
  `HAQP_ASSERT(a_one_step, !(cmd.mul && cmd.acc))

endmodule

// ----- hdl/hilbert_allpass_quadrature_pair.sv -----
// ---------------------------------------------------------------------------
// hilbert_allpass_quadrature_pair
// allpass-pair hilbert transformer with two cascades of allpass sections
// ---------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries one signed sample per
//   transaction; the result channel out_valid / out_stall returns the
//   in-phase (branch a, one sample late) and quadrature (branch b) pair
//   per input transaction
//   coefficients are written through cfg_we / cfg_index / cfg_data while idle
// schedule:
//   one multiplier serves all 2*SECTIONS_PER_BRANCH sections, each as a
//   multiply step, then a round/subtract/saturate step, and the result then
//   loads the output register; no new sample is accepted until the result
//   of the last one is published
// reset:
//   synchronous, clears all section histories, the held in-phase value and
//   output valid, and reloads the default coefficients
// stall:
//   a finished result waits in the output register while the next sample
//   is already accepted and processed; the following result waits for it
// ---------------------------------------------------------------------------
module hilbert_allpass_quadrature_pair #(
  parameter int SECTIONS_PER_BRANCH = haqp_pkg::SECTIONS_DEF,
  parameter int SAMPLE_BITS         = haqp_pkg::SAMPLE_DEF,
  parameter int COEF_FRAC_BITS      = haqp_pkg::COEF_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_in_phase,
  output logic signed [SAMPLE_BITS-1:0]  out_quadrature,
  input  logic                           cfg_we,
  input  logic [haqp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [haqp_pkg::COEF_W-1:0]    cfg_data
);

  haqp_pkg::cmd_t cmd;
  haqp_pkg::sts_t sts;

  haqp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  haqp_dp #(
    .SECTIONS_PER_BRANCH (SECTIONS_PER_BRANCH),
    .SAMPLE_BITS         (SAMPLE_BITS),
    .COEF_FRAC_BITS      (COEF_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample_in  (in_sample_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_phase   (out_in_phase),
    .quadrature (out_quadrature)
  );

endmodule
